[rtl/qte_pkg.sv]
// shared types, widths and the arctangent table for the quaternion to euler block
`default_nettype none

package qte_pkg;

  // datapath widths
  localparam int ArgW      = 35;   // atan2 arguments in Q.2F before scaling
  localparam int RootW     = 64;   // square root remainder and partial root
  localparam int CordW     = 46;   // cordic x and y after the x256 scaling
  localparam int AngW      = 34;   // angle accumulator, centidegrees in Q.16
  localparam int ProdW     = 32;   // one 16 x 16 product
  localparam int TabLen    = 24;
  localparam int RootSteps = 32;
  localparam int PreShift  = 8;
  localparam int AngFrac   = 16;

  localparam logic signed [AngW-1:0] QuarterTurn = 34'sd589824000;
  localparam logic signed [AngW-1:0] RoundHalf   = 34'sd32768;
  localparam logic signed [AngW-1:0] RollLim     = 34'sd18000;
  localparam logic signed [AngW-1:0] PitchLim    = 34'sd9000;

  // the five atan2 arguments
  typedef struct packed {
    logic signed [ArgW-1:0] roll_y;
    logic signed [ArgW-1:0] roll_x;
    logic signed [ArgW-1:0] pitch_y;
    logic signed [ArgW-1:0] yaw_y;
    logic signed [ArgW-1:0] yaw_x;
  } args_t;

  // square root cell payload
  typedef struct packed {
    logic [RootW-1:0] rem;
    logic [RootW-1:0] root;
    args_t            args;
  } root_t;

  // one cordic lane
  typedef struct packed {
    logic signed [CordW-1:0] x;
    logic signed [CordW-1:0] y;
    logic signed [AngW-1:0]  z;
    logic                    zero;
  } lane_t;

  // atan(2^-i) in centidegrees, Q.16, rounded to nearest
  function automatic logic signed [AngW-1:0] atan_entry(input int idx);
    logic signed [AngW-1:0] v;
    case (idx)
      0:  v = 34'sd294912000;
      1:  v = 34'sd174096719;
      2:  v = 34'sd91987925;
      3:  v = 34'sd46694507;
      4:  v = 34'sd23437865;
      5:  v = 34'sd11730358;
      6:  v = 34'sd5866610;
      7:  v = 34'sd2933484;
      8:  v = 34'sd1466765;
      9:  v = 34'sd733385;
      10: v = 34'sd366693;
      11: v = 34'sd183346;
      12: v = 34'sd91673;
      13: v = 34'sd45837;
      14: v = 34'sd22918;
      15: v = 34'sd11459;
      16: v = 34'sd5730;
      17: v = 34'sd2865;
      18: v = 34'sd1432;
      19: v = 34'sd716;
      20: v = 34'sd358;
      21: v = 34'sd179;
      22: v = 34'sd90;
      23: v = 34'sd45;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

[rtl/qte_if.sv]
// valid/ready channel interfaces for quaternions in and angles out
`default_nettype none

interface qte_quat_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface qte_angle_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] roll_centideg;
  logic signed [14:0] pitch_centideg;
  logic signed [15:0] yaw_centideg;

  modport source (output valid, roll_centideg, pitch_centideg, yaw_centideg, input ready);
  modport sink   (input valid, roll_centideg, pitch_centideg, yaw_centideg, output ready);
endinterface

`default_nettype wire

[rtl/qte_front.sv]
// front stages: products, argument sums with pitch clamp, and the root radicand
`default_nettype none

module qte_front
  import qte_pkg::*;
#(
  parameter int FracBits = 14
) (
  input  wire logic              clk_i,
  input  wire logic [2:0]        en_i,
  input  wire logic signed [15:0] quat_w_i,
  input  wire logic signed [15:0] quat_x_i,
  input  wire logic signed [15:0] quat_y_i,
  input  wire logic signed [15:0] quat_z_i,
  output root_t                  root_o
);

  localparam logic signed [ArgW-1:0] One   = {{(ArgW-1){1'b0}}, 1'b1} << (2 * FracBits);
  localparam logic [RootW-1:0]       OneSq = {{(RootW-1){1'b0}}, 1'b1} << (4 * FracBits);

  logic signed [ProdW-1:0] wx_q, yz_q, xx_q, yy_q, wy_q, zx_q, wz_q, xy_q, zz_q;
  args_t                   args_d, args_q;
  logic signed [ArgW-1:0]  pitch_raw;
  logic signed [2*ProdW-1:0] sq;
  root_t                   root_d, root_q;

  // stage 0: the nine products
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      wx_q <= quat_w_i * quat_x_i;
      yz_q <= quat_y_i * quat_z_i;
      xx_q <= quat_x_i * quat_x_i;
      yy_q <= quat_y_i * quat_y_i;
      wy_q <= quat_w_i * quat_y_i;
      zx_q <= quat_z_i * quat_x_i;
      wz_q <= quat_w_i * quat_z_i;
      xy_q <= quat_x_i * quat_y_i;
      zz_q <= quat_z_i * quat_z_i;
    end
  end

  // stage 1: argument sums, pitch argument clamped to +-1.0
  always_comb begin
    args_d.roll_y = (ArgW'(wx_q) + ArgW'(yz_q)) <<< 1;
    args_d.roll_x = One - ((ArgW'(xx_q) + ArgW'(yy_q)) <<< 1);
    args_d.yaw_y  = (ArgW'(wz_q) + ArgW'(xy_q)) <<< 1;
    args_d.yaw_x  = One - ((ArgW'(yy_q) + ArgW'(zz_q)) <<< 1);
    pitch_raw     = (ArgW'(wy_q) - ArgW'(zx_q)) <<< 1;
    if (pitch_raw > One) begin
      args_d.pitch_y = One;
    end else if (pitch_raw < -One) begin
      args_d.pitch_y = -One;
    end else begin
      args_d.pitch_y = pitch_raw;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      args_q <= args_d;
    end
  end

  // stage 2: radicand 1 - s^2 for the pitch cosine
  always_comb begin
    sq          = $signed(args_q.pitch_y[ProdW-1:0]) * $signed(args_q.pitch_y[ProdW-1:0]);
    root_d.rem  = OneSq - $unsigned(sq);
    root_d.root = '0;
    root_d.args = args_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      root_q <= root_d;
    end
  end

  assign root_o = root_q;

endmodule

`default_nettype wire

[rtl/qte_root_cell.sv]
// one step of the bit-serial square root, one result bit per cell
`default_nettype none

module qte_root_cell
  import qte_pkg::*;
#(
  parameter int Step = 0
) (
  input  wire logic clk_i,
  input  wire logic en_i,
  input  root_t     root_i,
  output root_t     root_o
);

  localparam logic [RootW-1:0] TrialBit = {{(RootW-1){1'b0}}, 1'b1} << (RootW - 2 - 2 * Step);

  logic [RootW-1:0] trial;
  root_t            root_d, root_q;

  // subtract the trial value where it fits
  always_comb begin
    trial       = root_i.root + TrialBit;
    root_d.args = root_i.args;
    if (root_i.rem >= trial) begin
      root_d.rem  = root_i.rem - trial;
      root_d.root = (root_i.root >> 1) + TrialBit;
    end else begin
      root_d.rem  = root_i.rem;
      root_d.root = root_i.root >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      root_q <= root_d;
    end
  end

  assign root_o = root_q;

endmodule

`default_nettype wire

[rtl/qte_cordic_cell.sv]
// one vectoring cordic micro-rotation for one lane
`default_nettype none

module qte_cordic_cell
  import qte_pkg::*;
#(
  parameter int Idx = 0
) (
  input  wire logic clk_i,
  input  wire logic en_i,
  input  lane_t     lane_i,
  output lane_t     lane_o
);

  localparam logic signed [AngW-1:0] Atan = atan_entry(Idx);

  lane_t lane_d, lane_q;

  // rotate toward the x axis
  always_comb begin
    lane_d.zero = lane_i.zero;
    if (lane_i.y >= 0) begin
      lane_d.x = lane_i.x + (lane_i.y >>> Idx);
      lane_d.y = lane_i.y - (lane_i.x >>> Idx);
      lane_d.z = lane_i.z + Atan;
    end else begin
      lane_d.x = lane_i.x - (lane_i.y >>> Idx);
      lane_d.y = lane_i.y + (lane_i.x >>> Idx);
      lane_d.z = lane_i.z - Atan;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule

`default_nettype wire

[rtl/quaternion_to_euler_angles.sv]
// top level: quaternion to zyx euler angles, a chain of pipelined cells
//
//   channel   dir   payload                                       transaction
//   quat_i    in    quat_w, quat_x, quat_y, quat_z (Q2.14)        valid & ready
//   angle_o   out   roll_centideg, pitch_centideg, yaw_centideg   valid & ready
//
// one transaction per cycle while angle_o is not stalled; the stages are:
// three front stages, 32 square root cells, a quadrant stage, the cordic cells
// and the output register.
// each stage moves when the stage after it is empty or moving, so bubbles close up
// and input is taken while a finished result waits, as long as some stage is empty.
// reset clears only the stage valid bits.
`default_nettype none

module quaternion_to_euler_angles
  import qte_pkg::*;
#(
  parameter int ANGLE_ITERATIONS = 16,
  parameter int QUAT_FRAC_BITS   = 14
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  qte_quat_if.sink    quat_i,
  qte_angle_if.source angle_o
);

  localparam int NumIter  = (ANGLE_ITERATIONS > TabLen) ? TabLen : ANGLE_ITERATIONS;
  localparam int RootBase = 3;
  localparam int QuadSt   = RootBase + RootSteps;
  localparam int OutSt    = QuadSt + 1 + NumIter;
  localparam int NumSt    = OutSt + 1;

  logic [NumSt-1:0] valid_q, adv;

  // stage advance chain
  for (genvar i = 0; i < NumSt; i++) begin : g_adv
    if (i == NumSt - 1) begin : g_last
      assign adv[i] = !valid_q[i] || angle_o.ready;
    end else begin : g_mid
      assign adv[i] = !valid_q[i] || adv[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (adv[0]) begin
        valid_q[0] <= quat_i.valid;
      end
      for (int i = 1; i < NumSt; i++) begin
        if (adv[i]) begin
          valid_q[i] <= valid_q[i-1];
        end
      end
    end
  end

  assign quat_i.ready = adv[0];

  // front stages
  root_t root_s [RootSteps+1];

  qte_front #(
    .FracBits(QUAT_FRAC_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .en_i     (adv[2:0]),
    .quat_w_i (quat_i.quat_w),
    .quat_x_i (quat_i.quat_x),
    .quat_y_i (quat_i.quat_y),
    .quat_z_i (quat_i.quat_z),
    .root_o   (root_s[0])
  );

  // square root chain
  for (genvar k = 0; k < RootSteps; k++) begin : g_root
    qte_root_cell #(
      .Step(k)
    ) u_cell (
      .clk_i  (clk_i),
      .en_i   (adv[RootBase+k]),
      .root_i (root_s[k]),
      .root_o (root_s[k+1])
    );
  end

  // quadrant fold and x256 scaling
  function automatic lane_t fold(input logic signed [ArgW-1:0] ay,
                                 input logic signed [ArgW-1:0] ax);
    lane_t l;
    logic signed [CordW-1:0] sx, sy;
    sx     = {{(CordW-ArgW-PreShift){ax[ArgW-1]}}, ax, {PreShift{1'b0}}};
    sy     = {{(CordW-ArgW-PreShift){ay[ArgW-1]}}, ay, {PreShift{1'b0}}};
    l.zero = (ax == '0) && (ay == '0);
    if (sx < 0) begin
      if (sy >= 0) begin
        l.x = sy;
        l.y = -sx;
        l.z = QuarterTurn;
      end else begin
        l.x = -sy;
        l.y = sx;
        l.z = -QuarterTurn;
      end
    end else begin
      l.x = sx;
      l.y = sy;
      l.z = '0;
    end
    return l;
  endfunction

  lane_t                  lane_s [NumIter+1][3];
  logic signed [ArgW-1:0] pitch_x;
  args_t                  args_r;

  assign args_r  = root_s[RootSteps].args;
  assign pitch_x = $signed({1'b0, root_s[RootSteps].root[ArgW-2:0]});

  always_ff @(posedge clk_i) begin
    if (adv[QuadSt]) begin
      lane_s[0][0] <= fold(args_r.roll_y, args_r.roll_x);
      lane_s[0][1] <= fold(args_r.pitch_y, pitch_x);
      lane_s[0][2] <= fold(args_r.yaw_y, args_r.yaw_x);
    end
  end

  // cordic chain, three lanes
  for (genvar s = 0; s < NumIter; s++) begin : g_cordic
    for (genvar ln = 0; ln < 3; ln++) begin : g_lane
      qte_cordic_cell #(
        .Idx(s)
      ) u_cell (
        .clk_i  (clk_i),
        .en_i   (adv[QuadSt+1+s]),
        .lane_i (lane_s[s][ln]),
        .lane_o (lane_s[s+1][ln])
      );
    end
  end

  // round half up and saturate; a zero vector gives zero
  function automatic logic signed [AngW-1:0] finish(input lane_t l,
                                                    input logic signed [AngW-1:0] lim);
    logic signed [AngW-1:0] a;
    a = (l.z + RoundHalf) >>> AngFrac;
    if (l.zero) begin
      a = '0;
    end else if (a > lim) begin
      a = lim;
    end else if (a < -lim) begin
      a = -lim;
    end
    return a;
  endfunction

  logic signed [AngW-1:0] roll_d, pitch_d, yaw_d;
  logic signed [15:0]     roll_q, yaw_q;
  logic signed [14:0]     pitch_q;

  assign roll_d  = finish(lane_s[NumIter][0], RollLim);
  assign pitch_d = finish(lane_s[NumIter][1], PitchLim);
  assign yaw_d   = finish(lane_s[NumIter][2], RollLim);

  // output register
  always_ff @(posedge clk_i) begin
    if (adv[OutSt]) begin
      roll_q  <= roll_d[15:0];
      pitch_q <= pitch_d[14:0];
      yaw_q   <= yaw_d[15:0];
    end
  end

  assign angle_o.valid          = valid_q[OutSt];
  assign angle_o.roll_centideg  = roll_q;
  assign angle_o.pitch_centideg = pitch_q;
  assign angle_o.yaw_centideg   = yaw_q;

  // an empty output stage opens the whole chain
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !angle_o.valid |-> quat_i.ready)
    else $error("input stalled with an empty output stage");

  // results stay inside their saturated ranges
  a_roll_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    angle_o.valid |-> (angle_o.roll_centideg <= 16'sd18000)
                   && (angle_o.roll_centideg >= -16'sd18000)
                   && (angle_o.yaw_centideg <= 16'sd18000)
                   && (angle_o.yaw_centideg >= -16'sd18000))
    else $error("roll or yaw outside range");

  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    angle_o.valid |-> (angle_o.pitch_centideg <= 15'sd9000)
                   && (angle_o.pitch_centideg >= -15'sd9000))
    else $error("pitch outside range");

endmodule

`default_nettype wire
